FILE: src/dpd_pkg.sv
// Shared types, constants and helpers for the double pendulum derivative pipeline.
// No dependencies; used by dpd_mulq, dpd_sincos, dpd_div and double_pendulum_derivative.
package dpd_pkg;

	typedef logic signed [63:0] wq_t;

	localparam int DATA_WIDTH_DEF  = 32;
	localparam int TRIG_STAGES_DEF = 24;
	localparam int CFG_W           = 32;
	localparam int CFG_IDX_W       = 3;

	localparam int MUL_LAT   = 3;
	localparam int DIV_STEPS = 87;
	localparam int DIV_LAT   = DIV_STEPS + 2;

	localparam wq_t WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	localparam logic [27:0] TWO_PI_Q24  = 28'd105414357;
	localparam logic [27:0] PI_Q24      = 28'd52707179;
	localparam logic [27:0] HALF_PI_Q24 = 28'd26353589;
	localparam logic [31:0] GAIN_Q30    = 32'd652032874;

	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
		32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAVITY      = 3'd0,
		REG_MASS_UPPER   = 3'd1,
		REG_MASS_LOWER   = 3'd2,
		REG_LENGTH_UPPER = 3'd3,
		REG_LENGTH_LOWER = 3'd4
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] GRAVITY_RST = 32'd642908;
	localparam logic [CFG_W-1:0] UNIT_RST    = 32'd65536;

	// modulo-2pi subtract steps for an angle of dw+2 bits
	function automatic int red_steps(input int dw);
		return (dw > 26) ? dw - 25 : 1;
	endfunction

	function automatic wq_t sadd(input wq_t a, input wq_t b);
		logic signed [64:0] s;
		logic signed [64:0] smax;
		smax = {1'b0, WMAX};
		s = {a[63], a} + {b[63], b};
		if (s > smax) begin
			return WMAX;
		end else if (s < -smax) begin
			return -WMAX;
		end
		return s[63:0];
	endfunction

endpackage

FILE: src/dpd_delay.sv
// Enabled shift-register delay line for pipeline alignment.
// No package dependencies.
module dpd_delay #(
	parameter int W     = 64,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				pipe_q[i] <= pipe_q[i-1];
			end
		end
	end

	assign q = pipe_q[DEPTH-1];

endmodule

FILE: src/dpd_mulq.sv
// Q31.32 saturating multiply, three stages: magnitude, 32x32 partials, combine.
// Uses dpd_pkg.
module dpd_mulq (
	input  logic        clk,
	input  logic        en,
	input  dpd_pkg::wq_t a,
	input  dpd_pkg::wq_t b,
	output dpd_pkg::wq_t p
);

	logic [63:0] ua_s1, ub_s1;
	logic        neg_s1, neg_s2;
	logic [63:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [63:0] mid, hi, r;
	dpd_pkg::wq_t p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1  <= a[63] ? 64'(-a) : 64'(a);
			ub_s1  <= b[63] ? 64'(-b) : 64'(b);
			neg_s1 <= a[63] ^ b[63];
			p00_s2 <= ua_s1[31:0] * ub_s1[31:0];
			p01_s2 <= ua_s1[31:0] * ub_s1[63:32];
			p10_s2 <= ua_s1[63:32] * ub_s1[31:0];
			p11_s2 <= ua_s1[63:32] * ub_s1[63:32];
			neg_s2 <= neg_s1;
			p_s3   <= neg_s2 ? -dpd_pkg::wq_t'(r) : dpd_pkg::wq_t'(r);
		end
	end

	always_comb begin
		mid = {32'b0, p00_s2[63:32]} + {32'b0, p01_s2[31:0]} + {32'b0, p10_s2[31:0]};
		hi  = p11_s2 + {32'b0, p01_s2[63:32]} + {32'b0, p10_s2[63:32]} + {32'b0, mid[63:32]};
		r   = (hi > 64'h7FFF_FFFF) ? 64'(dpd_pkg::WMAX) : {hi[31:0], mid[31:0]};
	end

	assign p = p_s3;

endmodule

FILE: src/dpd_sincos.sv
// Sine and cosine of a Q9.24 angle: modulo-2pi reduction, quadrant fold,
// pipelined rotation-mode CORDIC; results in Q31.32. Uses dpd_pkg.
module dpd_sincos #(
	parameter int TRIG_STAGES = dpd_pkg::TRIG_STAGES_DEF,
	parameter int DATA_WIDTH  = dpd_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DATA_WIDTH+1:0] angle,
	output dpd_pkg::wq_t                 sin_val,
	output dpd_pkg::wq_t                 cos_val
);

	localparam int AW = DATA_WIDTH + 2;
	localparam int RW = AW - 1;
	localparam int KR = dpd_pkg::red_steps(DATA_WIDTH);
	localparam int RS = 29;
	localparam int CW = 34;

	logic [RW-1:0] rem_q [KR+1];
	logic          neg_q [KR+1];

	logic signed [RS-1:0] rr_q;
	logic signed [RS-1:0] rr1, rr2, rr3;

	logic signed [CW-1:0] x_q [TRIG_STAGES+1];
	logic signed [CW-1:0] y_q [TRIG_STAGES+1];
	logic signed [CW-1:0] z_q [TRIG_STAGES+1];
	logic                 flip_q [TRIG_STAGES+1];
	logic                 flip_f;

	dpd_pkg::wq_t sin_q, cos_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= angle[AW-1] ? RW'(-angle) : RW'(angle);
			neg_q[0] <= angle[AW-1];
		end
	end

	for (genvar j = 0; j < KR; j++) begin : g_red
		localparam logic [RW+27:0] SUBV = (RW+28)'(dpd_pkg::TWO_PI_Q24) << (KR - 1 - j);
		logic [RW+27:0] ext;
		assign ext = {28'b0, rem_q[j]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j+1] <= (ext >= SUBV) ? RW'(ext - SUBV) : rem_q[j];
				neg_q[j+1] <= neg_q[j];
			end
		end
	end

	always_comb begin
		rr1 = signed'(RS'(rem_q[KR]));
		if (neg_q[KR] && rem_q[KR] != '0) begin
			rr1 = signed'(RS'(dpd_pkg::TWO_PI_Q24)) - rr1;
		end
		rr2 = rr_q;
		flip_f = 1'b0;
		if (rr_q > signed'(RS'(dpd_pkg::HALF_PI_Q24))) begin
			rr2 = signed'(RS'(dpd_pkg::PI_Q24)) - rr_q;
			flip_f = 1'b1;
		end else if (rr_q < -signed'(RS'(dpd_pkg::HALF_PI_Q24))) begin
			rr2 = -signed'(RS'(dpd_pkg::PI_Q24)) - rr_q;
			flip_f = 1'b1;
		end
		rr3 = (rr1 > signed'(RS'(dpd_pkg::PI_Q24))) ?
			rr1 - signed'(RS'(dpd_pkg::TWO_PI_Q24)) : rr1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_q      <= rr3;
			x_q[0]    <= signed'(CW'(dpd_pkg::GAIN_Q30));
			y_q[0]    <= '0;
			z_q[0]    <= {{(CW-RS){rr2[RS-1]}}, rr2} <<< 6;
			flip_q[0] <= flip_f;
		end
	end

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
		localparam logic signed [CW-1:0] ATV = signed'(CW'(dpd_pkg::ATAN_Q30[i]));
		logic signed [CW-1:0] dx, dy;
		assign dx = y_q[i] >>> i;
		assign dy = x_q[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][CW-1]) begin
					x_q[i+1] <= x_q[i] - dx;
					y_q[i+1] <= y_q[i] + dy;
					z_q[i+1] <= z_q[i] - ATV;
				end else begin
					x_q[i+1] <= x_q[i] + dx;
					y_q[i+1] <= y_q[i] - dy;
					z_q[i+1] <= z_q[i] + ATV;
				end
				flip_q[i+1] <= flip_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= {{(64-CW){y_q[TRIG_STAGES][CW-1]}}, y_q[TRIG_STAGES]} <<< 2;
			if (flip_q[TRIG_STAGES]) begin
				cos_q <= -({{(64-CW){x_q[TRIG_STAGES][CW-1]}}, x_q[TRIG_STAGES]} <<< 2);
			end else begin
				cos_q <= {{(64-CW){x_q[TRIG_STAGES][CW-1]}}, x_q[TRIG_STAGES]} <<< 2;
			end
		end
	end

	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

FILE: src/dpd_div.sv
// Pipelined restoring divider: trunc(n * 2^24 / d), one quotient bit per stage,
// saturated to DATA_WIDTH bits, zero for a zero divisor. Uses dpd_pkg.
module dpd_div #(
	parameter int DATA_WIDTH = dpd_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  dpd_pkg::wq_t          n,
	input  dpd_pkg::wq_t          d,
	output logic [DATA_WIDTH-1:0] q
);

	localparam int NS = dpd_pkg::DIV_STEPS;
	localparam logic [50:0] LIM = 51'(1) << (DATA_WIDTH - 1);

	logic [62:0] un_q  [NS+1];
	logic [62:0] ud_q  [NS+1];
	logic [62:0] rem_q [NS+1];
	logic [50:0] quo_q [NS+1];
	logic        big_q [NS+1];
	logic        neg_q [NS+1];
	logic        dz_q  [NS+1];

	logic [63:0] un, ud;
	logic [50:0] qs;
	logic [DATA_WIDTH-1:0] q_s;

	assign un = n[63] ? 64'(-n) : 64'(n);
	assign ud = d[63] ? 64'(-d) : 64'(d);

	always_ff @(posedge clk) begin
		if (en) begin
			un_q[0]  <= un[62:0];
			ud_q[0]  <= ud[62:0];
			rem_q[0] <= '0;
			quo_q[0] <= '0;
			big_q[0] <= 1'b0;
			neg_q[0] <= n[63] ^ d[63];
			dz_q[0]  <= (d == '0);
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_step
		localparam int K = NS - 1 - j;
		logic [63:0] remn;
		logic        ge;
		if (K >= 24) begin : g_bit
			assign remn = {rem_q[j], un_q[j][K-24]};
		end else begin : g_zero
			assign remn = {rem_q[j], 1'b0};
		end
		assign ge = remn >= {1'b0, ud_q[j]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j+1] <= ge ? 63'(remn - {1'b0, ud_q[j]}) : remn[62:0];
				if (!big_q[j]) begin
					quo_q[j+1] <= {quo_q[j][49:0], ge};
					big_q[j+1] <= quo_q[j][49];
				end else begin
					quo_q[j+1] <= quo_q[j];
					big_q[j+1] <= 1'b1;
				end
				un_q[j+1]  <= un_q[j];
				ud_q[j+1]  <= ud_q[j];
				neg_q[j+1] <= neg_q[j];
				dz_q[j+1]  <= dz_q[j];
			end
		end
	end

	always_comb begin
		if (neg_q[NS]) begin
			qs = (big_q[NS] || quo_q[NS] > LIM) ? LIM : quo_q[NS];
			qs = 51'(0) - qs;
		end else begin
			qs = (big_q[NS] || quo_q[NS] > LIM - 51'(1)) ? LIM - 51'(1) : quo_q[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s <= dz_q[NS] ? '0 : qs[DATA_WIDTH-1:0];
		end
	end

	assign q = q_s;

endmodule

FILE: src/double_pendulum_derivative.sv
// Double pendulum derivative: rates passed through, angular accelerations computed.
// Uses dpd_pkg, dpd_delay, dpd_mulq, dpd_sincos, dpd_div.
// The result path runs through the trig pipeline, the k1/pa and ib1/l1den
// multiplies and the 87-step divider.
// Throughput: one item per cycle; a held result stalls the whole pipeline.
// Reset clears valid bits and loads the default gravity, masses and lengths.
module double_pendulum_derivative #(
	parameter int TRIG_STAGES = dpd_pkg::TRIG_STAGES_DEF,
	parameter int DATA_WIDTH  = dpd_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// angle_upper, rate_upper, angle_lower, rate_lower
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// angle_upper_slope, accel_upper, angle_lower_slope, accel_lower
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	input  logic                            cfg_wen,
	input  logic [dpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dpd_pkg::CFG_W-1:0]       cfg_data
);

	localparam int DW  = DATA_WIDTH;
	localparam int TW  = ((4*DW+7)/8)*8;
	localparam int AW  = DW + 2;
	localparam int T   = dpd_pkg::red_steps(DW) + TRIG_STAGES + 4;
	localparam int ML  = dpd_pkg::MUL_LAT;
	localparam int LAT = T + 9 + dpd_pkg::DIV_LAT;

	logic [dpd_pkg::CFG_W-1:0] grav_q, m1_q, m2_q, l1_q, l2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= dpd_pkg::GRAVITY_RST;
			m1_q   <= dpd_pkg::UNIT_RST;
			m2_q   <= dpd_pkg::UNIT_RST;
			l1_q   <= dpd_pkg::UNIT_RST;
			l2_q   <= dpd_pkg::UNIT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				dpd_pkg::REG_GRAVITY:      grav_q <= cfg_data;
				dpd_pkg::REG_MASS_UPPER:   m1_q   <= cfg_data;
				dpd_pkg::REG_MASS_LOWER:   m2_q   <= cfg_data;
				dpd_pkg::REG_LENGTH_UPPER: l1_q   <= cfg_data;
				dpd_pkg::REG_LENGTH_LOWER: l2_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	dpd_pkg::wq_t g, m1, m2, l1, l2, tm, msum;
	assign g    = {16'b0, grav_q, 16'b0};
	assign m1   = {16'b0, m1_q, 16'b0};
	assign m2   = {16'b0, m2_q, 16'b0};
	assign l1   = {16'b0, l1_q, 16'b0};
	assign l2   = {16'b0, l2_q, 16'b0};
	assign tm   = dpd_pkg::sadd(dpd_pkg::sadd(m1, m1), m2);
	assign msum = dpd_pkg::sadd(m1, m2);

	logic en;
	logic [LAT-1:0] vld_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	logic signed [DW-1:0] t1_s1, t2_s1;
	logic [DW-1:0]        r1_s1, r2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1 <= s_tdata[DW-1:0];
			r1_s1 <= s_tdata[2*DW-1:DW];
			t2_s1 <= s_tdata[3*DW-1:2*DW];
			r2_s1 <= s_tdata[4*DW-1:3*DW];
		end
	end

	logic signed [AW-1:0] t1e, t2e, ang_d, ang_a, ang_2d;
	dpd_pkg::wq_t w1, w2;
	assign t1e    = {{2{t1_s1[DW-1]}}, t1_s1};
	assign t2e    = {{2{t2_s1[DW-1]}}, t2_s1};
	assign ang_d  = t1e - t2e;
	assign ang_a  = t1e - (t2e <<< 1);
	assign ang_2d = (t1e - t2e) <<< 1;
	assign w1     = {{(56-DW){r1_s1[DW-1]}}, r1_s1, 8'b0};
	assign w2     = {{(56-DW){r2_s1[DW-1]}}, r2_s1, 8'b0};

	dpd_pkg::wq_t s1, c1, sd, cd, sa, c2d;

	dpd_sincos #(.TRIG_STAGES(TRIG_STAGES), .DATA_WIDTH(DW)) u_sc1 (
		.clk, .en, .angle(t1e), .sin_val(s1), .cos_val(c1));
	dpd_sincos #(.TRIG_STAGES(TRIG_STAGES), .DATA_WIDTH(DW)) u_scd (
		.clk, .en, .angle(ang_d), .sin_val(sd), .cos_val(cd));
	dpd_sincos #(.TRIG_STAGES(TRIG_STAGES), .DATA_WIDTH(DW)) u_sca (
		.clk, .en, .angle(ang_a), .sin_val(sa), .cos_val());
	dpd_sincos #(.TRIG_STAGES(TRIG_STAGES), .DATA_WIDTH(DW)) u_sc2 (
		.clk, .en, .angle(ang_2d), .sin_val(), .cos_val(c2d));

	// products ready before the trig results
	dpd_pkg::wq_t w1sq, w2sq, gtm, m2g, gms, w1l1, w2l2, w1l1ms, w2l2m2;

	dpd_mulq u_w1sq   (.clk, .en, .a(w1),   .b(w1),   .p(w1sq));
	dpd_mulq u_w2sq   (.clk, .en, .a(w2),   .b(w2),   .p(w2sq));
	dpd_mulq u_gtm    (.clk, .en, .a(g),    .b(tm),   .p(gtm));
	dpd_mulq u_m2g    (.clk, .en, .a(m2),   .b(g),    .p(m2g));
	dpd_mulq u_gms    (.clk, .en, .a(g),    .b(msum), .p(gms));
	dpd_mulq u_w1l1   (.clk, .en, .a(w1sq), .b(l1),   .p(w1l1));
	dpd_mulq u_w2l2   (.clk, .en, .a(w2sq), .b(l2),   .p(w2l2));
	dpd_mulq u_w1l1ms (.clk, .en, .a(w1l1), .b(msum), .p(w1l1ms));
	dpd_mulq u_w2l2m2 (.clk, .en, .a(w2l2), .b(m2),   .p(w2l2m2));

	dpd_pkg::wq_t w1l1_d, w2l2_d, w1l1ms_d, w2l2m2_d, gtm_d, m2g_d, gms_d;

	dpd_delay #(.W(64), .DEPTH(T-2*ML)) u_dw1l1 (.clk, .en, .d(w1l1), .q(w1l1_d));
	dpd_delay #(.W(64), .DEPTH(T-ML)) u_dw2l2 (.clk, .en, .d(w2l2), .q(w2l2_d));
	dpd_delay #(.W(64), .DEPTH(T-2*ML)) u_dw1ms (.clk, .en, .d(w1l1ms), .q(w1l1ms_d));
	dpd_delay #(.W(64), .DEPTH(T-3*ML)) u_dw2m2 (.clk, .en, .d(w2l2m2), .q(w2l2m2_d));
	dpd_delay #(.W(64), .DEPTH(T-ML)) u_dgtm (.clk, .en, .d(gtm), .q(gtm_d));
	dpd_delay #(.W(64), .DEPTH(T-ML)) u_dm2g (.clk, .en, .d(m2g), .q(m2g_d));
	dpd_delay #(.W(64), .DEPTH(T-ML)) u_dgms (.clk, .en, .d(gms), .q(gms_d));

	dpd_pkg::wq_t m2c, k1, k2, pa, sdm2, pb, pc;

	dpd_mulq u_m2c  (.clk, .en, .a(m2),       .b(c2d), .p(m2c));
	dpd_mulq u_k1   (.clk, .en, .a(gtm_d),    .b(s1),  .p(k1));
	dpd_mulq u_k2   (.clk, .en, .a(m2g_d),    .b(sa),  .p(k2));
	dpd_mulq u_pa   (.clk, .en, .a(w1l1_d),   .b(cd),  .p(pa));
	dpd_mulq u_sdm2 (.clk, .en, .a(sd),       .b(m2),  .p(sdm2));
	dpd_mulq u_pb   (.clk, .en, .a(gms_d),    .b(c1),  .p(pb));
	dpd_mulq u_pc   (.clk, .en, .a(w2l2m2_d), .b(cd),  .p(pc));

	dpd_pkg::wq_t den_s4, inner1_s4, inner2_s4, sdm2_d, sd_d, k1_d, k2_d;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4    <= dpd_pkg::sadd(tm, -m2c);
			inner1_s4 <= dpd_pkg::sadd(w2l2_d, pa);
			inner2_s4 <= dpd_pkg::sadd(dpd_pkg::sadd(w1l1ms_d, pb), pc);
		end
	end

	dpd_delay #(.W(64), .DEPTH(1))    u_dsdm2 (.clk, .en, .d(sdm2), .q(sdm2_d));
	dpd_delay #(.W(64), .DEPTH(ML+1)) u_dsd   (.clk, .en, .d(sd),   .q(sd_d));
	dpd_delay #(.W(64), .DEPTH(ML+1)) u_dk1   (.clk, .en, .d(k1),   .q(k1_d));
	dpd_delay #(.W(64), .DEPTH(ML+1)) u_dk2   (.clk, .en, .d(k2),   .q(k2_d));

	dpd_pkg::wq_t ib1, ib2, l1den, l2den;

	dpd_mulq u_ib1   (.clk, .en, .a(sdm2_d), .b(inner1_s4), .p(ib1));
	dpd_mulq u_ib2   (.clk, .en, .a(sd_d),   .b(inner2_s4), .p(ib2));
	dpd_mulq u_l1den (.clk, .en, .a(l1),     .b(den_s4),    .p(l1den));
	dpd_mulq u_l2den (.clk, .en, .a(l2),     .b(den_s4),    .p(l2den));

	dpd_pkg::wq_t n1_s8, n2_s8, l1den_s8, l2den_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s8    <= dpd_pkg::sadd(dpd_pkg::sadd(-k1_d, -k2_d), -dpd_pkg::sadd(ib1, ib1));
			n2_s8    <= dpd_pkg::sadd(ib2, ib2);
			l1den_s8 <= l1den;
			l2den_s8 <= l2den;
		end
	end

	logic [DW-1:0] acc1, acc2;

	dpd_div #(.DATA_WIDTH(DW)) u_div1 (.clk, .en, .n(n1_s8), .d(l1den_s8), .q(acc1));
	dpd_div #(.DATA_WIDTH(DW)) u_div2 (.clk, .en, .n(n2_s8), .d(l2den_s8), .q(acc2));

	logic [2*DW-1:0] rates_d;

	dpd_delay #(.W(2*DW), .DEPTH(LAT-1)) u_drate (
		.clk, .en, .d({r2_s1, r1_s1}), .q(rates_d));

	assign m_tdata = TW'({acc2, rates_d[2*DW-1:DW], acc1, rates_d[DW-1:0]});

endmodule

FILE: src/dpd_check.sv
// Port-level checks for double_pendulum_derivative, bound to the top level.
// Uses no package.
module dpd_check #(
	parameter int DATA_WIDTH = 32
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("held result changed");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output empty");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("item taken while pipeline stalled");

endmodule

bind double_pendulum_derivative dpd_check #(.DATA_WIDTH(DATA_WIDTH)) u_check (.*);

FILE: verif/double_pendulum_derivative_test.sv
// Self-checking bench for double_pendulum_derivative: streams pendulum states and
// checks rates and accelerations against a bit-exact fixed-point predictor.
// Depends on dpd_pkg and the RTL in src.
module double_pendulum_derivative_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef dpd_pkg::wq_t wq_t;

	localparam int  LIMIT   = 400000;
	localparam int  TSTAGES = dpd_pkg::TRIG_STAGES_DEF;
	localparam wq_t TWO_PI  = 64'sd105414357;
	localparam wq_t PI      = 64'sd52707179;
	localparam wq_t HALF_PI = 64'sd26353589;
	localparam wq_t GAIN    = 64'sd652032874;

	typedef struct packed {
		logic signed [31:0] rate_lower;
		logic signed [31:0] angle_lower;
		logic signed [31:0] rate_upper;
		logic signed [31:0] angle_upper;
	} state_t;

	typedef struct packed {
		logic signed [31:0] accel_lower;
		logic signed [31:0] angle_lower_slope;
		logic signed [31:0] accel_upper;
		logic signed [31:0] angle_upper_slope;
	} slope_t;

	typedef struct {
		state_t st;
		bit     typed;
		logic signed [31:0] acc_u;
		logic signed [31:0] acc_l;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         cfg_wen = 1'b0;
	logic [dpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dpd_pkg::CFG_W-1:0]     cfg_data = '0;

	logic [31:0] gravity, mass_upper, mass_lower, length_upper, length_lower;
	slope_t slope_q[$];
	int  errors = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;
	int  hold_len = 0;
	bit  typed_next = 1'b0;
	logic signed [31:0] typed_u, typed_l;

	double_pendulum_derivative u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic wq_t sat_sum(input wq_t a, input wq_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > $signed({1'b0, dpd_pkg::WMAX}))
			return dpd_pkg::WMAX;
		if (s < -$signed({1'b0, dpd_pkg::WMAX}))
			return -dpd_pkg::WMAX;
		return s[63:0];
	endfunction

	function automatic wq_t fx_mul(input wq_t a, input wq_t b);
		logic [63:0]  ua, ub, r;
		logic [127:0] p;
		bit neg;
		neg = a[63] != b[63];
		ua = a[63] ? 64'(-a) : 64'(a);
		ub = b[63] ? 64'(-b) : 64'(b);
		p = ({64'd0, ua} * {64'd0, ub}) >> 32;
		r = (p > {64'd0, dpd_pkg::WMAX}) ? dpd_pkg::WMAX : p[63:0];
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] fx_div(input wq_t n, input wq_t d);
		logic [63:0]  un, ud;
		logic [127:0] q;
		bit neg;
		if (d == 0)
			return '0;
		neg = n[63] != d[63];
		un = n[63] ? 64'(-n) : 64'(n);
		ud = d[63] ? 64'(-d) : 64'(d);
		q = ({64'd0, un} << 24) / {64'd0, ud};
		if (neg) begin
			if (q > 128'h8000_0000)
				q = 128'h8000_0000;
			return 32'(-q);
		end
		if (q > 128'h7FFF_FFFF)
			q = 128'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic void sin_cos(input wq_t a, output wq_t s, output wq_t c);
		wq_t r, x, y, z, dx, dy;
		bit flip;
		flip = 1'b0;
		r = a % TWO_PI;
		if (r < 0) r = r + TWO_PI;
		if (r > PI) r = r - TWO_PI;
		if (r > HALF_PI) begin
			r = PI - r;
			flip = 1'b1;
		end else if (r < -HALF_PI) begin
			r = -PI - r;
			flip = 1'b1;
		end
		z = r * 64;
		x = GAIN;
		y = 0;
		for (int i = 0; i < TSTAGES && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - $signed({32'd0, dpd_pkg::ATAN_Q30[i]});
			end else begin
				x = x + dx; y = y - dy; z = z + $signed({32'd0, dpd_pkg::ATAN_Q30[i]});
			end
		end
		s = y * 4;
		c = flip ? -x * 4 : x * 4;
	endfunction

	function automatic slope_t pendulum_slope(input state_t st);
		wq_t t1, t2, w1, w2, g, m1, m2, l1, l2;
		wq_t s1, c1, sd, cd, sa, ca, s2d, c2d;
		wq_t w1sq, w2sq, two_m1, msum, den, n1, n2, inner, k1, k2;
		slope_t o;
		t1 = wq_t'(st.angle_upper);
		t2 = wq_t'(st.angle_lower);
		w1 = wq_t'(st.rate_upper) * 256;
		w2 = wq_t'(st.rate_lower) * 256;
		g  = $signed({32'd0, gravity}) <<< 16;
		m1 = $signed({32'd0, mass_upper}) <<< 16;
		m2 = $signed({32'd0, mass_lower}) <<< 16;
		l1 = $signed({32'd0, length_upper}) <<< 16;
		l2 = $signed({32'd0, length_lower}) <<< 16;
		sin_cos(t1, s1, c1);
		sin_cos(t1 - t2, sd, cd);
		sin_cos(t1 - 2 * t2, sa, ca);
		sin_cos(2 * t1 - 2 * t2, s2d, c2d);
		w1sq = fx_mul(w1, w1);
		w2sq = fx_mul(w2, w2);
		two_m1 = sat_sum(m1, m1);
		msum = sat_sum(m1, m2);
		den = sat_sum(sat_sum(two_m1, m2), -fx_mul(m2, c2d));
		k1 = fx_mul(fx_mul(g, sat_sum(two_m1, m2)), s1);
		k2 = fx_mul(fx_mul(m2, g), sa);
		inner = sat_sum(fx_mul(w2sq, l2), fx_mul(fx_mul(w1sq, l1), cd));
		inner = fx_mul(fx_mul(sd, m2), inner);
		n1 = sat_sum(sat_sum(-k1, -k2), -sat_sum(inner, inner));
		inner = sat_sum(fx_mul(fx_mul(w1sq, l1), msum), fx_mul(fx_mul(g, msum), c1));
		inner = sat_sum(inner, fx_mul(fx_mul(fx_mul(w2sq, l2), m2), cd));
		inner = fx_mul(sd, inner);
		n2 = sat_sum(inner, inner);
		o.angle_upper_slope = st.rate_upper;
		o.accel_upper       = fx_div(n1, fx_mul(l1, den));
		o.angle_lower_slope = st.rate_lower;
		o.accel_lower       = fx_div(n2, fx_mul(l2, den));
		return o;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: check, then choose next ready
	always @(posedge clk) begin
		slope_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (slope_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item %h", got);
			end else begin
				want = slope_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("item mismatch: exp %h %h %h %h act %h %h %h %h",
							want.angle_upper_slope, want.accel_upper,
							want.angle_lower_slope, want.accel_lower,
							got.angle_upper_slope, got.accel_upper,
							got.angle_lower_slope, got.accel_lower);
				end
			end
		end
		if (hold_len > 0) begin
			hold_len--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle_on || ($urandom_range(99) >= 33);
		end
	end

	task automatic send_state(input state_t st);
		slope_t o;
		while (idle_on && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= st;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		o = pendulum_slope(st);
		if (typed_next) begin
			o.accel_upper = typed_u;
			o.accel_lower = typed_l;
		end
		slope_q.push_back(o);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (slope_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [dpd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] v);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			dpd_pkg::REG_GRAVITY:      gravity = v;
			dpd_pkg::REG_MASS_UPPER:   mass_upper = v;
			dpd_pkg::REG_MASS_LOWER:   mass_lower = v;
			dpd_pkg::REG_LENGTH_UPPER: length_upper = v;
			dpd_pkg::REG_LENGTH_LOWER: length_lower = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] g, m1, m2, l1, l2);
		write_reg(dpd_pkg::REG_GRAVITY, g);
		write_reg(dpd_pkg::REG_MASS_UPPER, m1);
		write_reg(dpd_pkg::REG_MASS_LOWER, m2);
		write_reg(dpd_pkg::REG_LENGTH_UPPER, l1);
		write_reg(dpd_pkg::REG_LENGTH_LOWER, l2);
	endtask

	function automatic state_t random_state();
		state_t st;
		if ($urandom_range(3) == 0) begin
			st = {$urandom, $urandom, $urandom, $urandom};
		end else begin
			st.angle_upper = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
			st.angle_lower = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
			st.rate_upper  = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
			st.rate_lower  = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
		end
		return st;
	endfunction

	row_t rows[$];

	initial begin
		state_t st;
		gravity = dpd_pkg::GRAVITY_RST;
		mass_upper = dpd_pkg::UNIT_RST;
		mass_lower = dpd_pkg::UNIT_RST;
		length_upper = dpd_pkg::UNIT_RST;
		length_lower = dpd_pkg::UNIT_RST;

		// defaults after reset: extremes and the fold boundaries
		rows.push_back('{'{0, 0, 0, 0}, 0, 0, 0});
		rows.push_back('{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 0, 0, 0});
		rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 0, 0, 0});
		rows.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000}, 0, 0, 0});
		rows.push_back('{'{0, 0, 0, 52707179}, 0, 0, 0});
		rows.push_back('{'{0, 0, 0, -52707179}, 0, 0, 0});
		rows.push_back('{'{0, 0, 0, 26353589}, 0, 0, 0});
		rows.push_back('{'{0, 0, 0, -26353590}, 0, 0, 0});
		rows.push_back('{'{0, 26353589, 0, 52707180}, 0, 0, 0});
		rows.push_back('{'{32'sh0100_0000, 105414357, 32'sh0100_0000, 0}, 0, 0, 0});
		rows.push_back('{'{-32'sh0300_0000, 32'sh0123_4567, 32'sh0500_0000, 32'sh0080_0000}, 0, 0, 0});
		rows.push_back('{'{1, -1, -1, 1}, 0, 0, 0});
		rows.push_back('{'{32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 0}, 0, 0, 0});
		rows.push_back('{'{32'sh0400_0000, 32'sh0100_0000, 0, -32'sh0100_0000}, 0, 0, 0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			typed_next = rows[i].typed;
			typed_u = rows[i].acc_u;
			typed_l = rows[i].acc_l;
			send_state(rows[i].st);
		end
		typed_next = 1'b0;
		drain();

		// zero masses: denominator vanishes, both accelerations read zero
		write_reg(dpd_pkg::REG_MASS_UPPER, 32'd0);
		write_reg(dpd_pkg::REG_MASS_LOWER, 32'd0);
		typed_next = 1'b1;
		typed_u = 0;
		typed_l = 0;
		for (int i = 0; i < 6; i++) begin
			st = (i < 4) ? rows[i].st : random_state();
			send_state(st);
		end
		typed_next = 1'b0;
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					write_all(dpd_pkg::GRAVITY_RST, dpd_pkg::UNIT_RST, dpd_pkg::UNIT_RST,
						dpd_pkg::UNIT_RST, dpd_pkg::UNIT_RST);
					idle_on = 1'b0;
					hold_len = 600;
				end
				1: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: write_all(32'd0, 32'd1, 32'd0, 32'd1, 32'd1);
				3: begin
					write_all($urandom, $urandom | 1, $urandom, $urandom | 1, $urandom | 1);
					// indexes past the last register are ignored
					for (int k = int'(dpd_pkg::REG_LENGTH_LOWER) + 1;
						k < (1 << dpd_pkg::CFG_IDX_W); k++)
						write_reg(dpd_pkg::CFG_IDX_W'(k), $urandom);
				end
				4: write_all($urandom_range(1 << 20), $urandom_range(1, 1 << 19),
					$urandom_range(1 << 19), $urandom_range(1, 1 << 19),
					$urandom_range(1, 1 << 19));
				default: write_all($urandom_range(1 << 18), $urandom_range(1, 1 << 17),
					$urandom_range(1 << 17), $urandom_range(1, 1 << 17),
					$urandom_range(1, 1 << 17));
			endcase
			for (int i = 0; i < 205; i++)
				send_state(random_state());
			drain();
			idle_on = 1'b1;
		end

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: filelist.f
src/dpd_pkg.sv
src/dpd_delay.sv
src/dpd_mulq.sv
src/dpd_sincos.sv
src/dpd_div.sv
src/double_pendulum_derivative.sv
src/dpd_check.sv
verif/double_pendulum_derivative_test.sv
